// File: rtl/i2da_pkg.sv
package i2da_pkg;

  // Field widths
  localparam int W_VALUE = 64;
  localparam int W_MODE  = 3;
  localparam int W_CHAR  = 7;
  localparam int W_WSEL  = 2;

  // Decimal digits needed for a 64-bit magnitude
  localparam int NUM_DIGITS = 20;
  localparam int W_BCD      = 4 * NUM_DIGITS;
  localparam int W_DIDX     = 5;

  // Bits of the mode field
  localparam int MODE_SIGNED_BIT = 0;

  // Width select codes (mode bits 2..1); the remaining codes act as 64-bit
  localparam logic [W_WSEL-1:0] WSEL_16 = 2'd0;
  localparam logic [W_WSEL-1:0] WSEL_32 = 2'd1;
  localparam logic [W_WSEL-1:0] WSEL_64 = 2'd2;

  // Characters
  localparam logic [W_CHAR-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [W_CHAR-1:0] CHAR_MINUS = 7'h2D;

  // Default depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One classified job: magnitude, sign flag and width select
  typedef struct packed {
    logic [W_VALUE-1:0] mag;
    logic               neg;
    logic [W_WSEL-1:0]  wsel;
  } job_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
  } q_stat_t;

  // Queue head seen by the back
  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

endpackage

// File: rtl/i2da_in_if.sv
interface i2da_in_if;
  logic                          valid;
  logic                          ready;
  logic [i2da_pkg::W_VALUE-1:0]  value;
  logic [i2da_pkg::W_MODE-1:0]   mode;

  modport source (output valid, output value, output mode, input ready);
  modport sink   (input valid, input value, input mode, output ready);
endinterface

// File: rtl/i2da_out_if.sv
interface i2da_out_if;
  logic                         valid;
  logic                         ready;
  logic [i2da_pkg::W_CHAR-1:0]  char_out;
  logic                         last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink   (input valid, input char_out, input last, output ready);
endinterface

// File: rtl/i2da_front.sv
module i2da_front (
  i2da_in_if.sink          in_ch,
  input  i2da_pkg::q_stat_t stat,
  output logic             push,
  output i2da_pkg::job_t   push_job
);

  logic [i2da_pkg::W_WSEL-1:0]  wsel;
  logic [i2da_pkg::W_VALUE-1:0] mask;
  logic [i2da_pkg::W_VALUE-1:0] masked;
  logic                         sign;

  // Take an item whenever the queue has room
  assign in_ch.ready = !stat.full;
  assign push        = in_ch.valid && !stat.full;

  // Select width mask and sign bit
  assign wsel = in_ch.mode[2:1];

  always_comb begin
    case (wsel)
      i2da_pkg::WSEL_16: begin
        mask = {{(i2da_pkg::W_VALUE-16){1'b0}}, {16{1'b1}}};
        sign = in_ch.value[15];
      end
      i2da_pkg::WSEL_32: begin
        mask = {{(i2da_pkg::W_VALUE-32){1'b0}}, {32{1'b1}}};
        sign = in_ch.value[31];
      end
      default: begin
        mask = {i2da_pkg::W_VALUE{1'b1}};
        sign = in_ch.value[i2da_pkg::W_VALUE-1];
      end
    endcase
  end

  // Negate signed negatives within the width; most negative wraps to itself
  assign masked        = in_ch.value & mask;
  assign push_job.neg  = in_ch.mode[i2da_pkg::MODE_SIGNED_BIT] && sign;
  assign push_job.mag  = push_job.neg ? ((~masked + 64'd1) & mask) : masked;
  assign push_job.wsel = wsel;

endmodule

// File: rtl/i2da_fifo.sv
module i2da_fifo #(
  parameter int DEPTH = i2da_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  i2da_pkg::job_t     push_job,
  output i2da_pkg::q_stat_t  stat,
  input  logic               pop,
  output i2da_pkg::q_head_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  i2da_pkg::job_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.job   = mem[rd_ptr];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/i2da_back.sv
module i2da_back (
  input  logic              clk,
  input  logic              rst,
  input  i2da_pkg::q_head_t head,
  output logic              pop,
  i2da_out_if.source        out_ch
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]                   state;
  logic [i2da_pkg::W_VALUE-1:0] shreg;
  logic [i2da_pkg::W_BCD-1:0]   bcd;
  logic [i2da_pkg::W_BCD-1:0]   bcd_adj;
  logic [6:0]                   cnt;
  logic                         sign_pend;
  logic [i2da_pkg::W_DIDX-1:0]  idx;
  logic [i2da_pkg::W_DIDX-1:0]  idx_top;
  logic [3:0]                   digit;
  logic                         o_valid;
  logic [i2da_pkg::W_CHAR-1:0]  o_char;
  logic                         o_last;
  logic                         load;

  assign pop = (state == S_IDLE) && head.valid;

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < i2da_pkg::NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // Locate the most significant nonzero digit, digit 0 if all are zero
  always_comb begin
    idx_top = '0;
    for (int i = 1; i < i2da_pkg::NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        idx_top = i2da_pkg::W_DIDX'(i);
      end
    end
  end

  assign digit = bcd[{idx, 2'b00} +: 4];
  assign load  = (state == S_EMIT) && (!o_valid || out_ch.ready);

  // Sequence conversion and emission
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sign_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            sign_pend <= head.job.neg;
            bcd       <= '0;
            case (head.job.wsel)
              i2da_pkg::WSEL_16: begin
                shreg <= head.job.mag << 48;
                cnt   <= 7'd16;
              end
              i2da_pkg::WSEL_32: begin
                shreg <= head.job.mag << 32;
                cnt   <= 7'd32;
              end
              default: begin
                shreg <= head.job.mag;
                cnt   <= 7'd64;
              end
            endcase
            state <= S_CONV;
          end
        end
        S_CONV: begin
          bcd   <= {bcd_adj[i2da_pkg::W_BCD-2:0], shreg[i2da_pkg::W_VALUE-1]};
          shreg <= shreg << 1;
          cnt   <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            state <= S_FIND;
          end
        end
        S_FIND: begin
          idx   <= idx_top;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (load) begin
            if (sign_pend) begin
              sign_pend <= 1'b0;
            end else if (idx == '0) begin
              state <= S_IDLE;
            end else begin
              idx <= idx - i2da_pkg::W_DIDX'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the current character until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (sign_pend) begin
        o_char <= i2da_pkg::CHAR_MINUS;
        o_last <= 1'b0;
      end else begin
        o_char <= i2da_pkg::CHAR_ZERO + {3'b000, digit};
        o_last <= (idx == '0);
      end
    end
  end

  assign out_ch.valid    = o_valid;
  assign out_ch.char_out = o_char;
  assign out_ch.last     = o_last;

endmodule

// File: rtl/integer_to_decimal_ascii_unit.sv
// Channel   Role    Payload                 Transfer when
// in_ch     sink    value[63:0], mode[2:0]  valid && ready
// out_ch    source  char_out[6:0], last     valid && ready
//
// The converter takes a number W bits wide (W = 16, 32 or 64) one bit
// per cycle through the BCD shift-add loop, then emits its characters.
// The front classifies and negates combinationally and parks jobs in a
// short queue, so new numbers are taken while the converter works.
// Reset is synchronous and clears the queue, sequencer and output valid.
// A stalled output holds its character; the converter waits behind it.
module integer_to_decimal_ascii_unit #(
  parameter int QUEUE_DEPTH = i2da_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  i2da_in_if.sink    in_ch,
  i2da_out_if.source out_ch
);

  logic              push;
  logic              pop;
  i2da_pkg::job_t    push_job;
  i2da_pkg::q_stat_t stat;
  i2da_pkg::q_head_t head;

  // Classify incoming numbers
  i2da_front u_front (
    .in_ch    (in_ch),
    .stat     (stat),
    .push     (push),
    .push_job (push_job)
  );

  // Decouple front and back
  i2da_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .stat     (stat),
    .pop      (pop),
    .head     (head)
  );

  // Convert and emit characters
  i2da_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// File: dv/tb_integer_to_decimal_ascii_unit.sv
`timescale 1ns / 100ps

module tb_integer_to_decimal_ascii_unit;

  // Mode codes: bit 0 is signed, bits 2..1 select the width
  localparam logic [i2da_pkg::W_MODE-1:0] MODE_U16     = 3'd0;
  localparam logic [i2da_pkg::W_MODE-1:0] MODE_S16     = 3'd1;
  localparam logic [i2da_pkg::W_MODE-1:0] MODE_U32     = 3'd2;
  localparam logic [i2da_pkg::W_MODE-1:0] MODE_S32     = 3'd3;
  localparam logic [i2da_pkg::W_MODE-1:0] MODE_U64     = 3'd4;
  localparam logic [i2da_pkg::W_MODE-1:0] MODE_S64     = 3'd5;
  localparam logic [i2da_pkg::W_MODE-1:0] MODE_U64_ALT = 3'd6;
  localparam logic [i2da_pkg::W_MODE-1:0] MODE_S64_ALT = 3'd7;

  localparam int RANDOM_NUMS  = 138;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_SPACING = 600;
  localparam int TAIL_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct {
    logic [i2da_pkg::W_VALUE-1:0] value;
    logic [i2da_pkg::W_MODE-1:0]  mode;
    bit                           drain_first;
  } num_item_t;

  typedef struct {
    logic [i2da_pkg::W_CHAR-1:0] ch;
    logic                        last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst;

  i2da_in_if  in_ch ();
  i2da_out_if out_ch ();

  integer_to_decimal_ascii_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  num_item_t  num_q[$];
  text_char_t text_q[$];
  num_item_t  nxt;
  int         mismatches = 0;
  int         cyc_count = 0;

  // Sender burst state
  int burst_left = 0;
  int gap_left = 0;

  // Receiver stall state
  logic [15:0] rx_pat = 16'hFFFF;
  int          rx_cyc = 0;
  int          chars_seen = 0;
  int          hold_left = 0;
  int          next_hold_at = 150;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Queue the decimal text that one number should produce
  function automatic void predict_text(input logic [i2da_pkg::W_VALUE-1:0] raw,
                                       input logic [i2da_pkg::W_MODE-1:0] md);
    logic [i2da_pkg::W_VALUE-1:0] mask;
    logic [i2da_pkg::W_VALUE-1:0] sign_mask;
    logic [i2da_pkg::W_VALUE-1:0] mag;
    logic [3:0]                   digs[$];
    logic                         neg;
    text_char_t                   tc;
    case (md[2:1])
      i2da_pkg::WSEL_16: begin
        mask = 64'h0000_0000_0000_FFFF;
        sign_mask = 64'h0000_0000_0000_8000;
      end
      i2da_pkg::WSEL_32: begin
        mask = 64'h0000_0000_FFFF_FFFF;
        sign_mask = 64'h0000_0000_8000_0000;
      end
      default: begin
        mask = '1;
        sign_mask = 64'h8000_0000_0000_0000;
      end
    endcase
    mag = raw & mask;
    neg = md[i2da_pkg::MODE_SIGNED_BIT] && ((mag & sign_mask) != 64'd0);
    // negation wraps in the width, so the most negative value stays as is
    if (neg) mag = (~mag + 64'd1) & mask;
    do begin
      digs.push_front(4'(mag % 64'd10));
      mag = mag / 64'd10;
    end while (mag != 64'd0);
    if (neg) begin
      tc.ch = i2da_pkg::CHAR_MINUS;
      tc.last = 1'b0;
      text_q.push_back(tc);
    end
    while (digs.size() != 0) begin
      tc.ch = i2da_pkg::CHAR_ZERO + i2da_pkg::W_CHAR'(digs.pop_front());
      tc.last = (digs.size() == 0);
      text_q.push_back(tc);
    end
  endfunction

  task automatic add_num(input logic [i2da_pkg::W_VALUE-1:0] value,
                         input logic [i2da_pkg::W_MODE-1:0] mode,
                         input bit drain_first);
    num_item_t it;
    it.value = value;
    it.mode = mode;
    it.drain_first = drain_first;
    num_q.push_back(it);
  endtask

  // Driver: offer queued numbers in bursts, predict each transfer
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
      in_ch.mode <= MODE_U16;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_text(in_ch.value, in_ch.mode);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (num_q.size() != 0 &&
                     !(num_q[0].drain_first && text_q.size() != 0)) begin
          nxt = num_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.value <= nxt.value;
          in_ch.mode <= nxt.mode;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
            gap_left = $urandom_range(1, 12);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall on a rotating pattern, with a long hold now and then
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) chars_seen++;
      rx_cyc++;
      if (rx_cyc % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: rx_pat = 16'hFFFF;
          1: rx_pat = 16'($urandom) | 16'h0001;
          2: rx_pat = 16'($urandom & $urandom) | 16'h0001;
          default: rx_pat = 16'($urandom | $urandom) | 16'h0001;
        endcase
      end
      if (hold_left == 0 && chars_seen >= next_hold_at) begin
        hold_left = HOLD_CYCLES;
        next_hold_at = next_hold_at + HOLD_SPACING;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rx_pat[0];
        rx_pat = {rx_pat[0], rx_pat[15:1]};
      end
    end
  end

  // Monitor: compare each character transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (text_q.size() == 0) begin
        $display("%0t: unexpected char %h last %b, nothing expected", $time,
                 out_ch.char_out, out_ch.last);
        mismatches++;
      end else begin
        if (out_ch.char_out !== text_q[0].ch) begin
          $display("%0t: char mismatch, expected %h got %h", $time, text_q[0].ch,
                   out_ch.char_out);
          mismatches++;
        end
        if (out_ch.last !== text_q[0].last) begin
          $display("%0t: last mismatch, expected %b got %b", $time, text_q[0].last,
                   out_ch.last);
          mismatches++;
        end
        void'(text_q.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [i2da_pkg::W_VALUE-1:0] v;
    logic [i2da_pkg::W_MODE-1:0]  m;
    int                           s;
    rst = 1'b1;

    // Directed: width extremes, most negative values, undefined modes
    add_num(64'd0, MODE_U16, 1'b0);
    add_num(64'h0000_0000_0000_FFFF, MODE_U16, 1'b0);
    add_num(64'hFFFF_FFFF_FFFF_0000, MODE_U16, 1'b0);
    add_num(64'd0, MODE_S16, 1'b0);
    add_num(64'h0000_0000_0000_8000, MODE_S16, 1'b0);
    add_num(64'h0000_0000_0000_FFFF, MODE_S16, 1'b0);
    add_num(64'h0000_0000_0000_7FFF, MODE_S16, 1'b0);
    add_num(64'd9, MODE_U32, 1'b0);
    add_num(64'd10, MODE_U32, 1'b0);
    add_num(64'h0000_0000_FFFF_FFFF, MODE_U32, 1'b0);
    add_num(64'h0000_0000_8000_0000, MODE_S32, 1'b0);
    add_num(64'h0000_0000_7FFF_FFFF, MODE_S32, 1'b0);
    add_num(64'hA5A5_A5A5_FFFF_FFFE, MODE_S32, 1'b0);
    add_num(64'hFFFF_FFFF_FFFF_FFFF, MODE_U64, 1'b1);
    add_num(64'd10000000000000000000, MODE_U64, 1'b0);
    add_num(64'd9999999999999999999, MODE_U64, 1'b0);
    add_num(64'h8000_0000_0000_0000, MODE_S64, 1'b0);
    add_num(64'hFFFF_FFFF_FFFF_FFFF, MODE_S64, 1'b0);
    add_num(64'h7FFF_FFFF_FFFF_FFFF, MODE_S64, 1'b0);
    add_num(64'hFFFF_FFFF_FFFF_FFFF, MODE_U64_ALT, 1'b0);
    add_num(64'h8000_0000_0000_0000, MODE_S64_ALT, 1'b0);
    add_num(64'h0000_0000_0000_0000, MODE_S64_ALT, 1'b0);

    // Random numbers from several value classes over all eight modes
    for (int i = 0; i < RANDOM_NUMS; i++) begin
      m = i2da_pkg::W_MODE'($urandom_range(MODE_U16, MODE_S64_ALT));
      case ($urandom_range(0, 5))
        0: v = {$urandom, $urandom};
        1: v = 64'($urandom_range(0, 99));
        2: begin
          v = 64'd1;
          repeat ($urandom_range(0, 19)) v = v * 64'd10;
          v = v + 64'($urandom_range(0, 2)) - 64'd1;
        end
        3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        4: v = ~(64'({$urandom}) >> $urandom_range(0, 31));
        default: begin
          case ($urandom_range(0, 2))
            0: s = 15;
            1: s = 31;
            default: s = 63;
          endcase
          if ($urandom_range(0, 1) == 1) v = (64'd1 << s) + 64'($urandom_range(0, 3));
          else v = (64'd1 << s) - 64'd1 - 64'($urandom_range(0, 3));
        end
      endcase
      add_num(v, m, (i == 0) || ($urandom_range(0, 39) == 0));
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Drain: all numbers taken, all text seen, then let the pipe settle
    while (num_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (text_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
